FILE: src/swm_pkg.sv
// Shared types and constants for the sliding-window median block.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package swm_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_DEF   = 64;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_value;
    logic signed [VALUE_W-1:0] old_value;
    logic                      old_valid;
  } swm_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] median;
    logic [COUNT_W-1:0]        count;
    logic [STATUS_W-1:0]       status;
  } swm_result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } swm_sts_t;

endpackage

`default_nettype wire

FILE: src/swm_core.sv
// Sorted store and its sequencer: scan, one shift sweep, insert, median read.
// Depends on swm_pkg. The store is a single-port-read, single-port-write RAM.
`default_nettype none

module swm_core #(
  parameter int WINDOW_DEPTH = swm_pkg::DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  swm_pkg::swm_item_t   item,
  input  wire                  take,
  output swm_pkg::swm_sts_t    sts,
  output swm_pkg::swm_result_t res
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int VW = swm_pkg::VALUE_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_SHIFT  = 4'd3;
  localparam logic [3:0] ST_PUT    = 4'd4;
  localparam logic [3:0] ST_MED_A  = 4'd5;
  localparam logic [3:0] ST_MED_B  = 4'd6;
  localparam logic [3:0] ST_MED_C  = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]                   state;
  logic signed [VW-1:0]         nv;
  logic signed [VW-1:0]         ov;
  logic                         lv;
  logic [CW-1:0]                held;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                lt;
  logic                         found;
  logic [AW-1:0]                kidx;
  logic                         pend;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                src;
  logic [AW-1:0]                stop;
  logic                         down;
  logic                         more;
  logic [AW-1:0]                pos;
  logic [swm_pkg::STATUS_W-1:0] status;
  logic signed [VW-1:0]         lo;
  logic signed [VW-1:0]         median;

  // store
  logic [VW-1:0]   mem [WINDOW_DEPTH];
  logic [VW-1:0]   rd;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [VW-1:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  logic                 issue;
  logic                 room;
  logic                 ov_below;
  logic [CW-1:0]        p_wide;
  logic [AW-1:0]        pos_d;
  logic [AW-1:0]        k;
  logic [AW-1:0]        mid_lo;
  logic [AW-1:0]        mid_hi;
  logic signed [VW:0]   pair_sum;

  assign issue    = (idx != held);
  assign room     = (held < CW'(WINDOW_DEPTH));
  assign ov_below = (ov < nv);
  assign p_wide   = lt - CW'(found && ov_below);
  assign pos_d    = AW'(p_wide);
  // without a removal the hole sits just past the last held value
  assign k        = found ? kidx : AW'(held);
  assign mid_lo   = AW'((held - CW'(1)) >> 1);
  assign mid_hi   = AW'(held >> 1);
  assign pair_sum = {lo[VW-1], lo} + {rd[VW-1], rd};

  always_comb begin
    raddr = idx[AW-1:0];
    we    = 1'b0;
    waddr = pos;
    wdata = nv;
    unique case (state)
      ST_SHIFT: begin
        raddr = src;
        we    = pend;
        waddr = down ? rd_addr + AW'(1) : rd_addr - AW'(1);
        wdata = rd;
      end
      ST_PUT: begin
        we = 1'b1;
      end
      ST_MED_A: raddr = mid_lo;
      ST_MED_B: raddr = mid_hi;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held  <= '0;
      pend  <= 1'b0;
      more  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            nv     <= item.new_value;
            ov     <= item.old_value;
            lv     <= item.old_valid;
            status <= swm_pkg::STAT_OK;
            idx    <= '0;
            lt     <= '0;
            found  <= 1'b0;
            pend   <= 1'b0;
            // leaving equals entering: store unchanged
            if (item.old_valid && (item.new_value == item.old_value)) begin
              state <= ST_MED_A;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend    <= issue;
          rd_addr <= idx[AW-1:0];
          if (issue) begin
            idx <= idx + CW'(1);
          end
          if (pend) begin
            if ($signed(rd) < nv) begin
              lt <= lt + CW'(1);
            end
            if (lv && !found && ($signed(rd) == ov)) begin
              found <= 1'b1;
              kidx  <= rd_addr;
            end
          end
          if (!issue) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          pend <= 1'b0;
          if (!found && !room) begin
            status <= lv ? swm_pkg::STAT_MISSING : swm_pkg::STAT_FULL;
            state  <= ST_MED_A;
          end else begin
            if (!found) begin
              held <= held + CW'(1);
              if (lv) begin
                status <= swm_pkg::STAT_MISSING;
              end
            end
            pos  <= pos_d;
            stop <= pos_d;
            more <= 1'b1;
            if (pos_d == k) begin
              state <= ST_PUT;
            end else if (pos_d < k) begin
              down  <= 1'b1;
              src   <= k - AW'(1);
              state <= ST_SHIFT;
            end else begin
              down  <= 1'b0;
              src   <= k + AW'(1);
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          pend    <= more;
          rd_addr <= src;
          src     <= down ? src - AW'(1) : src + AW'(1);
          if (src == stop) begin
            more <= 1'b0;
          end
          if (!more) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          pend  <= 1'b0;
          state <= ST_MED_A;
        end
        ST_MED_A: begin
          if (held == '0) begin
            median <= '0;
            state  <= ST_DONE;
          end else begin
            state <= ST_MED_B;
          end
        end
        ST_MED_B: begin
          lo    <= rd;
          state <= ST_MED_C;
        end
        ST_MED_C: begin
          // even count: floor of the mean of the two middle words
          median <= held[0] ? lo : pair_sum[VW:1];
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sts.idle   = (state == ST_IDLE);
  assign sts.done   = (state == ST_DONE);
  assign res.median = median;
  assign res.count  = swm_pkg::COUNT_W'(held);
  assign res.status = status;

endmodule

`default_nettype wire

FILE: src/sliding_window_median.sv
// Sliding-window median: each word passes a scan of the held words, a shift of the stored
// words that move, an insert and a median read; the shift is skipped when none move, shift
// and insert for a dropped word, and scan, shift and insert when leaving equals entering.
// One word at a time: the next word can be taken in the cycle after the result is handed to
// the output register; the scan over held words dominates.
// Reset (rst, synchronous) empties the window and drops any pending result.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_DEPTH = swm_pkg::DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_stall,
  input  swm_pkg::swm_item_t   item,
  output logic                 result_valid,
  input  wire                  result_stall,
  output swm_pkg::swm_result_t result
);

  swm_pkg::swm_sts_t    sts;
  swm_pkg::swm_result_t res;
  logic                 start;
  logic                 take;

  assign item_stall = !sts.idle;
  assign start      = item_valid && !item_stall;
  assign take       = sts.done && (!result_valid || !result_stall);

  swm_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .item (item),
    .take (take),
    .sts  (sts),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

FILE: src/swm_checker.sv
// Port-level checks for sliding_window_median, attached by bind.
// Depends on swm_pkg and on the top level's port list.
`default_nettype none

module swm_checker #(
  parameter int WINDOW_DEPTH = swm_pkg::DEPTH_DEF
) (
  input wire                  clk,
  input wire                  rst,
  input wire                  item_valid,
  input wire                  item_stall,
  input swm_pkg::swm_item_t   item,
  input wire                  result_valid,
  input wire                  result_stall,
  input swm_pkg::swm_result_t result
);

  // a taken word keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("block not busy after accepting a word");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled input word changed");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == swm_pkg::STAT_FULL)
      |-> result.count == swm_pkg::COUNT_W'(WINDOW_DEPTH))
    else $error("overflow reported with store not full");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == swm_pkg::STAT_OK) ||
      (result.status == swm_pkg::STAT_MISSING) || (result.status == swm_pkg::STAT_FULL))
    else $error("undefined status code");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind sliding_window_median swm_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_swm_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .item        (item),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

`default_nettype wire
